// ===== rtl/tbpe_pkg.sv =====
package tbpe_pkg;

  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 15;
  localparam int COUNT_W  = 14;
  localparam int LEVEL_W  = 8;
  localparam int PERM_W   = 11;
  localparam int AMP_W    = 7;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 15;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_TIMING    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_AMPLITUDE = 3'd1;
  localparam logic [CIDX_W-1:0] REG_INVERT    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PILOT     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SYNC1     = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SYNC2     = 3'd5;
  localparam logic [CIDX_W-1:0] REG_ZERO      = 3'd6;
  localparam logic [CIDX_W-1:0] REG_ONE       = 3'd7;

  // duration slots
  localparam int NUM_DUR = 5;
  localparam int DIDX_W  = 3;
  localparam logic [DIDX_W-1:0] DUR_PILOT = 3'd0;
  localparam logic [DIDX_W-1:0] DUR_SYNC1 = 3'd1;
  localparam logic [DIDX_W-1:0] DUR_SYNC2 = 3'd2;
  localparam logic [DIDX_W-1:0] DUR_ZERO  = 3'd3;
  localparam logic [DIDX_W-1:0] DUR_ONE   = 3'd4;

  // run sequence of one item
  localparam int RUN_W = 4;
  localparam logic [RUN_W-1:0] RUN_PILOT = 4'd0;
  localparam logic [RUN_W-1:0] RUN_SYNC1 = 4'd1;
  localparam logic [RUN_W-1:0] RUN_SYNC2 = 4'd2;
  localparam logic [RUN_W-1:0] RUN_BIT7  = 4'd3;
  localparam logic [RUN_W-1:0] RUN_BIT0  = 4'd10;

  localparam logic [BYTE_W-1:0]  FLAG_DATA  = 8'h80;
  localparam logic [LEVEL_W-1:0] MID_LEVEL  = 8'd128;
  localparam logic [TICK_W-1:0]  TICK_MIN   = 15'd1;
  localparam logic [TICK_W-1:0]  TICK_MAX   = 15'd32767;
  localparam logic [COUNT_W-1:0] COUNT_SYNC = 14'd1;
  localparam logic [COUNT_W-1:0] COUNT_BIT  = 14'd2;

  // scaling: (ticks * permille + 500) / 1000, the divide done as
  // ((x >> 3) * ceil(2^30 / 125)) >> 30, exact for x below 2^26
  localparam int PROD_W      = TICK_W + PERM_W;
  localparam logic [PROD_W-1:0] ROUND_ADD = 26'd500;
  localparam int DIV_SHIFT   = 3;
  localparam int XQ_W        = PROD_W - DIV_SHIFT;
  localparam int RECIP_W     = 24;
  localparam int RECIP_HALF  = RECIP_W / 2;
  localparam logic [RECIP_W-1:0] RECIP = 24'd8589935;
  localparam int RECIP_SHIFT = 30;
  localparam int PART_W      = XQ_W + RECIP_HALF;
  localparam int SUM_W       = XQ_W + RECIP_W + 1;
  localparam int QUOT_W      = SUM_W - 1 - RECIP_SHIFT;

  typedef logic [TICK_W-1:0] tick_t;
  typedef tick_t [NUM_DUR-1:0] dur_set_t;

  typedef struct packed {
    logic [PERM_W-1:0] timing_permille;
    logic [AMP_W-1:0]  amplitude;
    logic              invert_output;
    tick_t             pilot_ticks;
    tick_t             sync_one_ticks;
    tick_t             sync_two_ticks;
    tick_t             zero_bit_ticks;
    tick_t             one_bit_ticks;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic [RUN_W-1:0] run;
  } seq_st_t;

endpackage

// ===== rtl/tbpe_in_if.sv =====
interface tbpe_in_if;
  logic                        valid;
  logic                        ready;
  logic [tbpe_pkg::BYTE_W-1:0] data_byte;
  logic                        first_of_block;
  logic                        last_of_block;

  modport source (output valid, output data_byte, output first_of_block,
                  output last_of_block, input ready);
  modport sink   (input valid, input data_byte, input first_of_block,
                  input last_of_block, output ready);
endinterface

// ===== rtl/tbpe_out_if.sv =====
interface tbpe_out_if;
  logic                         valid;
  logic                         ready;
  logic [tbpe_pkg::TICK_W-1:0]  pulse_ticks;
  logic [tbpe_pkg::COUNT_W-1:0] pulse_count;
  logic [tbpe_pkg::LEVEL_W-1:0] start_level;
  logic                         block_end;
  logic                         last;

  modport source (output valid, output pulse_ticks, output pulse_count,
                  output start_level, output block_end, output last, input ready);
  modport sink   (input valid, input pulse_ticks, input pulse_count,
                  input start_level, input block_end, input last, output ready);
endinterface

// ===== rtl/tbpe_cfg_if.sv =====
interface tbpe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tbpe_pkg::CIDX_W-1:0]  index;
  logic [tbpe_pkg::CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tbpe_cfg_regs.sv =====
module tbpe_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  tbpe_cfg_if.sink         cfg_ch,
  output tbpe_pkg::cfg_t   cfg,
  output logic             cfg_wr
);

  tbpe_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid & cfg_ch.ready;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timing_permille <= 11'd1000;
      cfg_r.amplitude       <= 7'd64;
      cfg_r.invert_output   <= 1'b0;
      cfg_r.pilot_ticks     <= 15'd6194;
      cfg_r.sync_one_ticks  <= 15'd1906;
      cfg_r.sync_two_ticks  <= 15'd2100;
      cfg_r.zero_bit_ticks  <= 15'd2443;
      cfg_r.one_bit_ticks   <= 15'd4886;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        tbpe_pkg::REG_TIMING:    cfg_r.timing_permille <= cfg_ch.data[tbpe_pkg::PERM_W-1:0];
        tbpe_pkg::REG_AMPLITUDE: cfg_r.amplitude       <= cfg_ch.data[tbpe_pkg::AMP_W-1:0];
        tbpe_pkg::REG_INVERT:    cfg_r.invert_output   <= cfg_ch.data[0];
        tbpe_pkg::REG_PILOT:     cfg_r.pilot_ticks     <= cfg_ch.data[tbpe_pkg::TICK_W-1:0];
        tbpe_pkg::REG_SYNC1:     cfg_r.sync_one_ticks  <= cfg_ch.data[tbpe_pkg::TICK_W-1:0];
        tbpe_pkg::REG_SYNC2:     cfg_r.sync_two_ticks  <= cfg_ch.data[tbpe_pkg::TICK_W-1:0];
        tbpe_pkg::REG_ZERO:      cfg_r.zero_bit_ticks  <= cfg_ch.data[tbpe_pkg::TICK_W-1:0];
        tbpe_pkg::REG_ONE:       cfg_r.one_bit_ticks   <= cfg_ch.data[tbpe_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tbpe_scaler.sv =====
module tbpe_scaler (
  input  logic               clk,
  input  logic               rst_n,
  input  tbpe_pkg::cfg_t     cfg,
  input  logic               cfg_wr,
  output tbpe_pkg::dur_set_t scaled,
  output logic               settled
);

  // a full sweep of all slots through the three stages
  localparam int SETTLE = tbpe_pkg::NUM_DUR + 2;
  localparam int SET_W  = $clog2(SETTLE + 1);

  logic [tbpe_pkg::DIDX_W-1:0]     idx_r, idx_nxt, idx_p_r, idx_q_r;
  logic [SET_W-1:0]                settle_r;
  tbpe_pkg::tick_t                 ticks_sel;
  logic [tbpe_pkg::PROD_W-1:0]     prod_r;
  logic [tbpe_pkg::XQ_W-1:0]       xq;
  logic [tbpe_pkg::PART_W-1:0]     part_lo_r, part_hi_r;
  logic [tbpe_pkg::SUM_W-1:0]      sum;
  logic [tbpe_pkg::QUOT_W-1:0]     quot;
  tbpe_pkg::tick_t                 clamped;
  tbpe_pkg::dur_set_t              scaled_r;

  assign scaled  = scaled_r;
  assign settled = (settle_r == '0);

  always_comb begin
    unique case (idx_r)
      tbpe_pkg::DUR_PILOT: ticks_sel = cfg.pilot_ticks;
      tbpe_pkg::DUR_SYNC1: ticks_sel = cfg.sync_one_ticks;
      tbpe_pkg::DUR_SYNC2: ticks_sel = cfg.sync_two_ticks;
      tbpe_pkg::DUR_ZERO:  ticks_sel = cfg.zero_bit_ticks;
      default:             ticks_sel = cfg.one_bit_ticks;
    endcase
  end

  assign idx_nxt = (idx_r == tbpe_pkg::DIDX_W'(tbpe_pkg::NUM_DUR - 1)) ? '0
                 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      settle_r <= SET_W'(SETTLE);
    end else begin
      idx_r <= idx_nxt;
      if (cfg_wr)
        settle_r <= SET_W'(SETTLE);
      else if (settle_r != '0)
        settle_r <= settle_r - 1'b1;
    end
  end

  assign xq = prod_r[tbpe_pkg::PROD_W-1:tbpe_pkg::DIV_SHIFT];

  // stage 1: raw product with rounding offset; stage 2: reciprocal halves
  always_ff @(posedge clk) begin
    prod_r    <= tbpe_pkg::PROD_W'(ticks_sel) * tbpe_pkg::PROD_W'(cfg.timing_permille)
               + tbpe_pkg::ROUND_ADD;
    idx_p_r   <= idx_r;
    part_lo_r <= tbpe_pkg::PART_W'(xq)
               * tbpe_pkg::PART_W'(tbpe_pkg::RECIP[tbpe_pkg::RECIP_HALF-1:0]);
    part_hi_r <= tbpe_pkg::PART_W'(xq)
               * tbpe_pkg::PART_W'(tbpe_pkg::RECIP[tbpe_pkg::RECIP_W-1:tbpe_pkg::RECIP_HALF]);
    idx_q_r   <= idx_p_r;
  end

  always_comb begin
    sum  = (tbpe_pkg::SUM_W'(part_hi_r) << tbpe_pkg::RECIP_HALF)
         + tbpe_pkg::SUM_W'(part_lo_r);
    quot = sum[tbpe_pkg::SUM_W-2:tbpe_pkg::RECIP_SHIFT];
    if (quot == '0)
      clamped = tbpe_pkg::TICK_MIN;
    else if (quot > tbpe_pkg::QUOT_W'(tbpe_pkg::TICK_MAX))
      clamped = tbpe_pkg::TICK_MAX;
    else
      clamped = quot[tbpe_pkg::TICK_W-1:0];
  end

  always_ff @(posedge clk) begin
    scaled_r[idx_q_r] <= clamped;
  end

endmodule

// ===== rtl/tbpe_run_seq.sv =====
module tbpe_run_seq #(
  parameter int HEADER_PILOT_COUNT = 8063,
  parameter int DATA_PILOT_COUNT   = 3223
) (
  input  logic                clk,
  input  logic                rst_n,
  tbpe_in_if.sink             in_ch,
  tbpe_out_if.source          out_ch,
  input  tbpe_pkg::cfg_t      cfg,
  input  tbpe_pkg::dur_set_t  scaled,
  input  logic                settled,
  output tbpe_pkg::seq_st_t   st
);

  localparam logic [tbpe_pkg::COUNT_W-1:0] HDR_CNT = tbpe_pkg::COUNT_W'(HEADER_PILOT_COUNT);
  localparam logic [tbpe_pkg::COUNT_W-1:0] DAT_CNT = tbpe_pkg::COUNT_W'(DATA_PILOT_COUNT);

  logic                             itm_valid_r;
  logic [tbpe_pkg::BYTE_W-1:0]      itm_byte_r;
  logic                             itm_last_r;
  logic [tbpe_pkg::RUN_W-1:0]       run_r;
  logic                             level_r;
  tbpe_pkg::dur_set_t               dur_r;

  logic                             out_valid_r;
  tbpe_pkg::tick_t                  ticks_r, ticks_nxt;
  logic [tbpe_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [tbpe_pkg::LEVEL_W-1:0]     dac_r, dac_nxt;
  logic                             end_r, last_r;

  logic                             adv, final_run, in_acc, lvl, phys, bit_val;
  logic [tbpe_pkg::COUNT_W-1:0]     pilot_cnt, in_pilot_cnt;
  logic [tbpe_pkg::LEVEL_W-1:0]     amp_ext;

  assign adv       = itm_valid_r & (~out_valid_r | out_ch.ready);
  assign final_run = (run_r == tbpe_pkg::RUN_BIT0);
  assign in_ch.ready = settled & (~itm_valid_r | (adv & final_run));
  assign in_acc    = in_ch.valid & in_ch.ready;

  assign in_pilot_cnt = (in_ch.data_byte < tbpe_pkg::FLAG_DATA) ? HDR_CNT : DAT_CNT;
  assign pilot_cnt    = (itm_byte_r < tbpe_pkg::FLAG_DATA) ? HDR_CNT : DAT_CNT;
  assign bit_val      = itm_byte_r[3'(tbpe_pkg::RUN_BIT0 - run_r)];

  // level_r already holds the level after the sync pulses of a first item
  always_comb begin
    ticks_nxt = bit_val ? dur_r[tbpe_pkg::DUR_ONE] : dur_r[tbpe_pkg::DUR_ZERO];
    count_nxt = tbpe_pkg::COUNT_BIT;
    lvl       = level_r;
    case (run_r)
      tbpe_pkg::RUN_PILOT: begin
        ticks_nxt = dur_r[tbpe_pkg::DUR_PILOT];
        count_nxt = pilot_cnt;
        lvl       = 1'b1;
      end
      tbpe_pkg::RUN_SYNC1: begin
        ticks_nxt = dur_r[tbpe_pkg::DUR_SYNC1];
        count_nxt = tbpe_pkg::COUNT_SYNC;
      end
      tbpe_pkg::RUN_SYNC2: begin
        ticks_nxt = dur_r[tbpe_pkg::DUR_SYNC2];
        count_nxt = tbpe_pkg::COUNT_SYNC;
        lvl       = ~level_r;
      end
      default: ;
    endcase
    phys    = lvl ^ cfg.invert_output;
    amp_ext = tbpe_pkg::LEVEL_W'(cfg.amplitude);
    dac_nxt = phys ? (tbpe_pkg::MID_LEVEL + amp_ext) : (tbpe_pkg::MID_LEVEL - amp_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itm_valid_r <= 1'b0;
      run_r       <= tbpe_pkg::RUN_PILOT;
      level_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        itm_valid_r <= 1'b1;
        run_r       <= in_ch.first_of_block ? tbpe_pkg::RUN_PILOT : tbpe_pkg::RUN_BIT7;
        if (in_ch.first_of_block)
          level_r <= ~in_pilot_cnt[0];
      end else if (adv) begin
        if (final_run)
          itm_valid_r <= 1'b0;
        else
          run_r <= run_r + 1'b1;
      end
      if (adv)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      itm_byte_r  <= in_ch.data_byte;
      itm_last_r  <= in_ch.last_of_block;
      if (in_ch.first_of_block)
        dur_r <= scaled;
    end
    if (adv) begin
      ticks_r <= ticks_nxt;
      count_r <= count_nxt;
      dac_r   <= dac_nxt;
      last_r  <= final_run;
      end_r   <= final_run & itm_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pulse_ticks = ticks_r;
  assign out_ch.pulse_count = count_r;
  assign out_ch.start_level = dac_r;
  assign out_ch.block_end   = end_r;
  assign out_ch.last        = last_r;

  assign st.busy = itm_valid_r;
  assign st.run  = run_r;

endmodule

// ===== rtl/tape_block_pulse_encoder.sv =====
// channel  dir  handshake      payload
// in_ch    in   valid/ready    data_byte, first_of_block, last_of_block
// out_ch   out  valid/ready    pulse_ticks, pulse_count, start_level, block_end, last
// cfg_ch   in   valid/ready    index, data (always ready)
//
// a first byte gives 11 runs, any other byte 8, one run a cycle from the run
// sequencer into the output register while the output is not stalled; the next item
// is taken as the last run of the current one leaves
// durations are scaled by a shared 3-stage multiply unit sweeping the five
// slots; input is held off after reset and after any cfg write until the
// sweep has settled; a stalled output holds its run and the sequencer waits behind it
module tape_block_pulse_encoder #(
  parameter int HEADER_PILOT_COUNT = 8063,
  parameter int DATA_PILOT_COUNT   = 3223
) (
  input  logic        clk,
  input  logic        rst_n,
  tbpe_in_if.sink     in_ch,
  tbpe_out_if.source  out_ch,
  tbpe_cfg_if.sink    cfg_ch
);

  tbpe_pkg::cfg_t     cfg;
  logic               cfg_wr;
  tbpe_pkg::dur_set_t scaled;
  logic               settled;
  tbpe_pkg::seq_st_t  st;

  tbpe_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg),
    .cfg_wr (cfg_wr)
  );

  tbpe_scaler u_scl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr),
    .scaled  (scaled),
    .settled (settled)
  );

  tbpe_run_seq #(
    .HEADER_PILOT_COUNT (HEADER_PILOT_COUNT),
    .DATA_PILOT_COUNT   (DATA_PILOT_COUNT)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .scaled  (scaled),
    .settled (settled),
    .st      (st)
  );

  a_acc_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> settled)
    else $error("item taken before durations settled");

  a_cfg_unsettles: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !settled)
    else $error("cfg write did not restart settling");

  a_first_pilot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.first_of_block)
      |=> (st.busy && st.run == tbpe_pkg::RUN_PILOT))
    else $error("first item did not start with pilot run");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.block_end) |-> out_ch.last)
    else $error("block end on a run that is not the item's last");

endmodule

// ===== dv/tape_block_pulse_encoder_tb.sv =====
module tape_block_pulse_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_PILOT = 8063;
  localparam int DAT_PILOT = 3223;
  localparam int MAX_GAP   = 18;
  localparam int SETTLE    = 16;
  localparam int WATCHDOG  = 2000;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 34;

  typedef logic [tbpe_pkg::COUNT_W-1:0] count_t;
  typedef logic [tbpe_pkg::LEVEL_W-1:0] level_t;

  typedef struct packed {
    tbpe_pkg::tick_t ticks;
    count_t          count;
    level_t          level;
    logic            block_end;
    logic            last;
  } pulse_run_t;

  typedef struct {
    bit                            is_cfg;
    logic [tbpe_pkg::CIDX_W-1:0]   reg_idx;
    logic [tbpe_pkg::CDATA_W-1:0]  reg_val;
    logic [tbpe_pkg::BYTE_W-1:0]   byte_v;
    bit                            first;
    bit                            last;
    bit                            typed;
    tbpe_pkg::tick_t               e_ticks;
    count_t                        e_count;
    level_t                        e_level;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tbpe_in_if  in_ch ();
  tbpe_out_if out_ch ();
  tbpe_cfg_if cfg_ch ();

  tape_block_pulse_encoder #(
    .HEADER_PILOT_COUNT (HDR_PILOT),
    .DATA_PILOT_COUNT   (DAT_PILOT)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // encoder shadow state
  tbpe_pkg::cfg_t     shadow;
  tbpe_pkg::dur_set_t latched;
  bit                 lvl_high;

  pulse_run_t runs_due [$];
  int unsigned mismatches;
  bit          quiet_phase;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tbpe_pkg::tick_t scale_dur(input tbpe_pkg::tick_t raw);
    longint unsigned v;
    v = raw;
    v = (v * shadow.timing_permille + 500) / 1000;
    if (v < tbpe_pkg::TICK_MIN) v = tbpe_pkg::TICK_MIN;
    if (v > tbpe_pkg::TICK_MAX) v = tbpe_pkg::TICK_MAX;
    return tbpe_pkg::tick_t'(v);
  endfunction

  function automatic void add_run(input tbpe_pkg::tick_t t, input count_t c);
    pulse_run_t r;
    r.ticks     = t;
    r.count     = c;
    r.level     = (lvl_high ^ shadow.invert_output)
                ? tbpe_pkg::MID_LEVEL + shadow.amplitude
                : tbpe_pkg::MID_LEVEL - shadow.amplitude;
    r.block_end = 1'b0;
    r.last      = 1'b0;
    runs_due.push_back(r);
    lvl_high ^= c[0];
  endfunction

  function automatic void predict_byte(input stim_row_t r);
    int     n0;
    int     k;
    int     b;
    count_t pc;
    n0 = runs_due.size();
    if (r.first) begin
      latched[tbpe_pkg::DUR_PILOT] = scale_dur(shadow.pilot_ticks);
      latched[tbpe_pkg::DUR_SYNC1] = scale_dur(shadow.sync_one_ticks);
      latched[tbpe_pkg::DUR_SYNC2] = scale_dur(shadow.sync_two_ticks);
      latched[tbpe_pkg::DUR_ZERO]  = scale_dur(shadow.zero_bit_ticks);
      latched[tbpe_pkg::DUR_ONE]   = scale_dur(shadow.one_bit_ticks);
      lvl_high = 1'b1;
      pc = (r.byte_v < tbpe_pkg::FLAG_DATA) ? count_t'(HDR_PILOT) : count_t'(DAT_PILOT);
      add_run(latched[tbpe_pkg::DUR_PILOT], pc);
      add_run(latched[tbpe_pkg::DUR_SYNC1], tbpe_pkg::COUNT_SYNC);
      add_run(latched[tbpe_pkg::DUR_SYNC2], tbpe_pkg::COUNT_SYNC);
    end
    for (b = tbpe_pkg::BYTE_W - 1; b >= 0; b--) begin
      add_run(latched[r.byte_v[b] ? tbpe_pkg::DUR_ONE : tbpe_pkg::DUR_ZERO],
              tbpe_pkg::COUNT_BIT);
    end
    k = runs_due.size() - 1;
    runs_due[k].last      = 1'b1;
    runs_due[k].block_end = r.last;
    // hand-worked values replace the predicted opening run
    if (r.typed) begin
      runs_due[n0].ticks = r.e_ticks;
      runs_due[n0].count = r.e_count;
      runs_due[n0].level = r.e_level;
    end
  endfunction

  function automatic void apply_cfg(input logic [tbpe_pkg::CIDX_W-1:0] idx,
                                    input logic [tbpe_pkg::CDATA_W-1:0] val);
    case (idx)
      tbpe_pkg::REG_TIMING:    shadow.timing_permille = val[tbpe_pkg::PERM_W-1:0];
      tbpe_pkg::REG_AMPLITUDE: shadow.amplitude       = val[tbpe_pkg::AMP_W-1:0];
      tbpe_pkg::REG_INVERT:    shadow.invert_output   = val[0];
      tbpe_pkg::REG_PILOT:     shadow.pilot_ticks     = val;
      tbpe_pkg::REG_SYNC1:     shadow.sync_one_ticks  = val;
      tbpe_pkg::REG_SYNC2:     shadow.sync_two_ticks  = val;
      tbpe_pkg::REG_ZERO:      shadow.zero_bit_ticks  = val;
      tbpe_pkg::REG_ONE:       shadow.one_bit_ticks   = val;
      default: ;
    endcase
  endfunction

  function automatic stim_row_t mk_item(input logic [tbpe_pkg::BYTE_W-1:0] b, input bit f,
                                        input bit l);
    stim_row_t r;
    r         = '{default: '0};
    r.byte_v  = b;
    r.first   = f;
    r.last    = l;
    return r;
  endfunction

  function automatic stim_row_t mk_typed(input logic [tbpe_pkg::BYTE_W-1:0] b, input bit f,
                                         input bit l, input tbpe_pkg::tick_t t,
                                         input count_t c, input level_t lv);
    stim_row_t r;
    r         = mk_item(b, f, l);
    r.typed   = 1'b1;
    r.e_ticks = t;
    r.e_count = c;
    r.e_level = lv;
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [tbpe_pkg::CIDX_W-1:0] idx,
                                       input logic [tbpe_pkg::CDATA_W-1:0] val);
    stim_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic send_item(input stim_row_t r);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= r.byte_v;
    in_ch.first_of_block <= r.first;
    in_ch.last_of_block  <= r.last;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(r);
  endtask

  // hold keeps valid up for a write that follows straight on
  task automatic cfg_write(input logic [tbpe_pkg::CIDX_W-1:0] idx,
                           input logic [tbpe_pkg::CDATA_W-1:0] val, input bit hold);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_cfg(idx, val);
    if (!hold) cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [tbpe_pkg::CDATA_W-1:0] rand_ticks();
    case ($urandom_range(0, 9))
      0:       return tbpe_pkg::CDATA_W'(tbpe_pkg::TICK_MAX);
      1:       return tbpe_pkg::CDATA_W'(tbpe_pkg::TICK_MIN);
      2:       return tbpe_pkg::CDATA_W'($urandom_range(0, 32767));
      default: return tbpe_pkg::CDATA_W'($urandom_range(1, 9000));
    endcase
  endfunction

  // result side
  initial begin
    pulse_run_t got;
    pulse_run_t want;
    int         stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
      got.ticks     = out_ch.pulse_ticks;
      got.count     = out_ch.pulse_count;
      got.level     = out_ch.start_level;
      got.block_end = out_ch.block_end;
      got.last      = out_ch.last;
      if (runs_due.size() == 0) begin
        $error("unexpected run: ticks %0d count %0d level %0d", got.ticks, got.count,
               got.level);
        mismatches++;
      end else begin
        want = runs_due.pop_front();
        if (got.ticks !== want.ticks) begin
          $error("pulse_ticks: expected %0d, got %0d", want.ticks, got.ticks);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("pulse_count: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
        if (got.level !== want.level) begin
          $error("start_level: expected %0d, got %0d", want.level, got.level);
          mismatches++;
        end
        if (got.block_end !== want.block_end) begin
          $error("block_end: expected %0b, got %0b", want.block_end, got.block_end);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t                    script [$];
    int                           i;
    int                           ph;
    int                           n;
    int                           j;
    int                           blen;
    bit                           f;
    bit                           l;
    logic [tbpe_pkg::BYTE_W-1:0]  bv;
    logic [tbpe_pkg::PERM_W-1:0]  perm;
    logic [tbpe_pkg::AMP_W-1:0]   amp;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.first_of_block = 1'b0;
    in_ch.last_of_block  = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = tbpe_pkg::REG_TIMING;
    cfg_ch.data          = '0;
    mismatches           = 0;
    idle_cycles          = 0;
    quiet_phase          = 1'b0;

    shadow.timing_permille = 11'd1000;
    shadow.amplitude       = 7'd64;
    shadow.invert_output   = 1'b0;
    shadow.pilot_ticks     = 15'd6194;
    shadow.sync_one_ticks  = 15'd1906;
    shadow.sync_two_ticks  = 15'd2100;
    shadow.zero_bit_ticks  = 15'd2443;
    shadow.one_bit_ticks   = 15'd4886;
    latched                = '0;
    lvl_high               = 1'b1;

    script = '{
      // header flag straight after reset, default timing
      mk_typed(8'h00, 1'b1, 1'b0, 15'd6194, 14'd8063, 8'd192),
      mk_item (8'hFF, 1'b0, 1'b0),
      mk_item (8'hA5, 1'b0, 1'b1),
      // continuation after a block end
      mk_item (8'h5A, 1'b0, 1'b0),
      mk_typed(8'h80, 1'b1, 1'b0, 15'd6194, 14'd3223, 8'd192),
      mk_typed(8'h7F, 1'b1, 1'b1, 15'd6194, 14'd8063, 8'd192),
      // top of the clamp, full swing, inverted
      mk_cfg(tbpe_pkg::REG_TIMING, 15'd2047),
      mk_cfg(tbpe_pkg::REG_AMPLITUDE, 15'd127),
      mk_cfg(tbpe_pkg::REG_INVERT, 15'd1),
      mk_cfg(tbpe_pkg::REG_PILOT, 15'd32767),
      mk_typed(8'hFF, 1'b1, 1'b0, 15'd32767, 14'd3223, 8'd1),
      mk_item (8'h00, 1'b0, 1'b1),
      // scale to nothing, bottom of the clamp, no swing
      mk_cfg(tbpe_pkg::REG_TIMING, 15'd0),
      mk_cfg(tbpe_pkg::REG_AMPLITUDE, 15'd0),
      mk_cfg(tbpe_pkg::REG_INVERT, 15'd0),
      mk_typed(8'h00, 1'b1, 1'b1, 15'd1, 14'd8063, 8'd128),
      mk_cfg(tbpe_pkg::REG_TIMING, 15'd1000),
      mk_cfg(tbpe_pkg::REG_AMPLITUDE, 15'd120),
      mk_cfg(tbpe_pkg::REG_PILOT, 15'd1),
      mk_cfg(tbpe_pkg::REG_SYNC1, 15'd32767),
      mk_cfg(tbpe_pkg::REG_SYNC2, 15'd0),
      mk_cfg(tbpe_pkg::REG_ZERO, 15'd1),
      mk_cfg(tbpe_pkg::REG_ONE, 15'd32767),
      mk_typed(8'h80, 1'b1, 1'b0, 15'd1, 14'd3223, 8'd248),
      mk_item (8'h3C, 1'b0, 1'b0),
      // levels change mid block, durations stay latched
      mk_cfg(tbpe_pkg::REG_AMPLITUDE, 15'd8),
      mk_cfg(tbpe_pkg::REG_INVERT, 15'd1),
      mk_item (8'hC3, 1'b0, 1'b1),
      mk_item (8'h96, 1'b0, 1'b1),
      mk_item (8'h01, 1'b0, 1'b0),
      // new block before the old one ended
      mk_item (8'hFE, 1'b1, 1'b1)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < script.size(); i++) begin
      if (script[i].is_cfg) begin
        if (i == 0 || !script[i-1].is_cfg) drain();
        cfg_write(script[i].reg_idx, script[i].reg_val,
                  (i + 1 < script.size()) && script[i+1].is_cfg);
      end else begin
        send_item(script[i]);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      quiet_phase = (ph % 3 == 2);
      if (ph == 0) begin
        perm = 11'd900;
        amp  = 7'd8;
      end else if (ph == 1) begin
        perm = 11'd1100;
        amp  = 7'd120;
      end else begin
        perm = ($urandom_range(0, 3) == 0) ? tbpe_pkg::PERM_W'($urandom_range(0, 2047))
                                           : tbpe_pkg::PERM_W'($urandom_range(900, 1100));
        amp  = ($urandom_range(0, 3) == 0) ? tbpe_pkg::AMP_W'($urandom_range(0, 127))
                                           : tbpe_pkg::AMP_W'($urandom_range(8, 120));
      end
      // spare upper data bits are random, the register ignores them
      cfg_write(tbpe_pkg::REG_TIMING, {4'($urandom_range(0, 15)), perm}, 1'b1);
      cfg_write(tbpe_pkg::REG_AMPLITUDE, {8'($urandom_range(0, 255)), amp}, 1'b1);
      cfg_write(tbpe_pkg::REG_INVERT, tbpe_pkg::CDATA_W'($urandom_range(0, 32767)), 1'b1);
      cfg_write(tbpe_pkg::REG_PILOT, rand_ticks(), 1'b1);
      cfg_write(tbpe_pkg::REG_SYNC1, rand_ticks(), 1'b1);
      cfg_write(tbpe_pkg::REG_SYNC2, rand_ticks(), 1'b1);
      cfg_write(tbpe_pkg::REG_ZERO, rand_ticks(), 1'b1);
      cfg_write(tbpe_pkg::REG_ONE, rand_ticks(), 1'b0);

      n = 0;
      while (n < PHASE_LEN) begin
        blen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 5);
        for (j = 0; j < blen; j++) begin
          f  = (j == 0);
          l  = (j == blen - 1);
          bv = tbpe_pkg::BYTE_W'($urandom_range(0, 255));
          if (f && $urandom_range(0, 3) == 0) bv = $urandom_range(0, 1) ? 8'h7F : 8'h80;
          // broken framing now and then
          if ($urandom_range(0, 11) == 0) f = ~f;
          if ($urandom_range(0, 11) == 0) l = ~l;
          send_item(mk_item(bv, f, l));
          n++;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
